/* rtl/tchfe_pkg.sv */
// Package: phase codes, result kinds and status codes of the ClientHello extractor.
`timescale 1ns / 1ps
package tchfe_pkg;
    localparam logic [4:0] PH_HDR      = 5'd0;
    localparam logic [4:0] PH_CV0      = 5'd1;
    localparam logic [4:0] PH_CV1      = 5'd2;
    localparam logic [4:0] PH_RANDOM   = 5'd3;
    localparam logic [4:0] PH_SIDLEN   = 5'd4;
    localparam logic [4:0] PH_SKIPSID  = 5'd5;
    localparam logic [4:0] PH_CSLEN0   = 5'd6;
    localparam logic [4:0] PH_CSLEN1   = 5'd7;
    localparam logic [4:0] PH_CIPHER   = 5'd8;
    localparam logic [4:0] PH_COMPLEN  = 5'd9;
    localparam logic [4:0] PH_SKIPCOMP = 5'd10;
    localparam logic [4:0] PH_EXTLEN0  = 5'd11;
    localparam logic [4:0] PH_EXTLEN1  = 5'd12;
    localparam logic [4:0] PH_ETYPE0   = 5'd13;
    localparam logic [4:0] PH_ETYPE1   = 5'd14;
    localparam logic [4:0] PH_ELEN0    = 5'd15;
    localparam logic [4:0] PH_ELEN1    = 5'd16;
    localparam logic [4:0] PH_SNI      = 5'd17;
    localparam logic [4:0] PH_SV       = 5'd18;
    localparam logic [4:0] PH_EC       = 5'd19;
    localparam logic [4:0] PH_PF       = 5'd20;
    localparam logic [4:0] PH_ESKIP    = 5'd21;
    localparam logic [4:0] PH_STOP     = 5'd22;
    localparam logic [4:0] PH_IDLE     = 5'd23;

    localparam logic [2:0] KIND_RECORD_VER = 3'd0;
    localparam logic [2:0] KIND_CLIENT_VER = 3'd1;
    localparam logic [2:0] KIND_CIPHER     = 3'd2;
    localparam logic [2:0] KIND_EXT_TYPE   = 3'd3;
    localparam logic [2:0] KIND_SNI_BYTE   = 3'd4;
    localparam logic [2:0] KIND_SUP_VER    = 3'd5;
    localparam logic [2:0] KIND_CURVE      = 3'd6;
    localparam logic [2:0] KIND_POINT_FMT  = 3'd7;

    localparam logic [1:0] ST_ACCEPTED   = 2'd0;
    localparam logic [1:0] ST_NOT_HS     = 2'd1;
    localparam logic [1:0] ST_NOT_CH     = 2'd2;
    localparam logic [1:0] ST_TOO_SHORT  = 2'd3;

    localparam logic [7:0]  CT_HANDSHAKE = 8'd22;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
    localparam logic [15:0] EXT_SNI      = 16'h0000;
    localparam logic [15:0] EXT_SUP_VER  = 16'h002B;
    localparam logic [15:0] EXT_CURVES   = 16'h000A;
    localparam logic [15:0] EXT_PT_FMT   = 16'h000B;
    localparam int          MIN_LEN      = 9;
    localparam int          BODY_MIN     = 35;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_of_payload;
        logic [15:0] payload_length;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  item_kind;
        logic [15:0] item_value;
        logic        end_of_message;
        logic [1:0]  end_status;
    } t_out_item;
endpackage

/* rtl/tchfe_if.sv */
// Interfaces: valid/ready channels for payload bytes and result items.
`timescale 1ns / 1ps
interface tchfe_in_if;
    logic                 valid;
    logic                 ready;
    tchfe_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tchfe_out_if;
    logic                 valid;
    logic                 ready;
    tchfe_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/tchfe_out_fifo.sv */
// Result queue: four entries, takes up to two results per cycle, gives one.
`timescale 1ns / 1ps
module tchfe_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push0,
    input  tchfe_pkg::t_out_item i_item0,
    input  logic                 i_push1,
    input  tchfe_pkg::t_out_item i_item1,
    output logic                 o_room,
    tchfe_out_if.source          o_res
);
    tchfe_pkg::t_out_item r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_pop;
    logic [1:0] w_np;
    logic [2:0] n_cnt;

    assign w_pop = o_res.valid && o_res.ready;
    assign w_np = {1'b0, i_push0} + {1'b0, i_push1};
    assign n_cnt = r_cnt + {1'b0, w_np} - {2'b0, w_pop};
    assign o_room = (r_cnt <= 3'd2);
    assign o_res.valid = (r_cnt != 3'd0);
    assign o_res.payload = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_pop) r_rp <= r_rp + 2'd1;
            r_wp <= r_wp + w_np;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) r_mem[r_wp] <= i_item0;
        if (i_push1) begin
            if (i_push0) r_mem[r_wp + 2'd1] <= i_item1;
            else r_mem[r_wp] <= i_item1;
        end
    end
endmodule

/* rtl/tls_client_hello_field_extractor.sv */
// Top level: TLS ClientHello field extractor.
`timescale 1ns / 1ps
// Use: feed payload bytes on i_req, one request per byte; raise start_of_payload with
// payload_length on the first byte of each payload. Results leave on o_res: tagged
// values (record version, client version, ciphers, extension types, SNI bytes,
// supported versions, curves, point formats), then one status item that ends the payload.
// Throughput: one byte per cycle while ready on i_req is high. Each byte is parsed by
// one step of the phase register and its bookkeeping registers; up to two results per
// byte go into a four-entry result queue.
// A result is written into the queue register when its byte is accepted.
// Reset: the parse returns to the record header phase with all counters cleared
// and the queue empties; bytes without a start are parsed as a zero-length payload.
// Stall: when the receiver holds o_res.ready low the queue fills; ready on i_req
// drops while fewer than two queue entries are free, so no request is lost.
module tls_client_hello_field_extractor #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tchfe_in_if.sink    i_req,
    tchfe_out_if.source o_res
);
    localparam int LB = LENGTH_BITS;
    // wide enough for a position plus a 16-bit length without wrapping
    localparam int W  = ((LB > 16) ? LB : 16) + 2;

    logic [LB-1:0] r_pos, r_total, r_flim;
    logic [15:0]   r_frem, r_erem, r_cext, r_list, r_bidx;
    logic [7:0]    r_hold;
    logic [4:0]    r_ph;
    logic [1:0]    r_rej;
    logic          r_half;

    logic [LB-1:0] n_pos, n_total, n_flim;
    logic [15:0]   n_frem, n_erem, n_cext, n_list, n_bidx;
    logic [7:0]    n_hold;
    logic [4:0]    n_ph;
    logic [1:0]    n_rej;
    logic          n_half;

    logic                 w_room, w_acc, w_p0, w_p1;
    tchfe_pkg::t_out_item w_it0, w_it1;
    logic [7:0]           b;
    logic [15:0]          v, w_k, w_len;
    logic [W-1:0]         w_nxt, w_tot, w_lim;

    assign i_req.ready = w_room;
    assign w_acc = i_req.valid && w_room;
    assign b = i_req.payload.data_byte;

    always_comb begin
        logic [LB-1:0] pos0, tot0;
        logic [4:0]    ph0;
        logic [15:0]   cext0;
        n_pos = r_pos; n_total = r_total; n_flim = r_flim; n_frem = r_frem;
        n_erem = r_erem; n_cext = r_cext; n_list = r_list; n_bidx = r_bidx;
        n_hold = r_hold; n_ph = r_ph; n_rej = r_rej; n_half = r_half;
        w_p0 = 1'b0; w_p1 = 1'b0; w_it0 = '0; w_it1 = '0;
        w_k = '0; w_len = '0;
        // restart the parse on a start byte
        if (i_req.payload.start_of_payload) begin
            n_pos = '0; n_ph = tchfe_pkg::PH_HDR; n_frem = '0; n_hold = '0;
            n_flim = '0; n_erem = '0; n_cext = '0; n_rej = '0; n_list = '0;
            n_bidx = '0; n_half = 1'b0;
            n_total = LB'(i_req.payload.payload_length);
        end
        pos0 = n_pos; tot0 = n_total; ph0 = n_ph; cext0 = n_cext;
        w_nxt = W'(pos0) + W'(1);
        w_tot = W'(tot0);
        w_lim = W'(n_flim);
        v = {n_hold, b};
        if (w_acc && ph0 != tchfe_pkg::PH_IDLE) begin
            case (ph0)
                tchfe_pkg::PH_HDR: begin
                    if (w_tot < W'(tchfe_pkg::MIN_LEN)) n_ph = tchfe_pkg::PH_STOP;
                    else if (pos0 == '0 && b != tchfe_pkg::CT_HANDSHAKE) begin
                        n_rej = tchfe_pkg::ST_NOT_HS; n_ph = tchfe_pkg::PH_STOP;
                    end else if (pos0 == LB'(1)) n_cext = {b, 8'd0};
                    else if (pos0 == LB'(2)) n_cext = cext0 | {8'd0, b};
                    else if (pos0 == LB'(5)) begin
                        if (b != tchfe_pkg::HS_CLIENT_HELLO) begin
                            n_rej = tchfe_pkg::ST_NOT_CH; n_ph = tchfe_pkg::PH_STOP;
                        end else begin
                            w_p0 = 1'b1;
                            w_it0.item_kind = tchfe_pkg::KIND_RECORD_VER;
                            w_it0.item_value = cext0;
                        end
                    end else if (pos0 >= LB'(8))
                        n_ph = (W'(tchfe_pkg::MIN_LEN + tchfe_pkg::BODY_MIN) > w_tot)
                            ? tchfe_pkg::PH_STOP : tchfe_pkg::PH_CV0;
                end
                tchfe_pkg::PH_CV0, tchfe_pkg::PH_CSLEN0, tchfe_pkg::PH_EXTLEN0,
                tchfe_pkg::PH_ETYPE0, tchfe_pkg::PH_ELEN0: begin
                    n_hold = b; n_ph = ph0 + 5'd1;
                end
                tchfe_pkg::PH_CV1: begin
                    w_p0 = 1'b1; w_it0.item_kind = tchfe_pkg::KIND_CLIENT_VER;
                    w_it0.item_value = v;
                    n_frem = 16'd32; n_ph = tchfe_pkg::PH_RANDOM;
                end
                tchfe_pkg::PH_RANDOM: begin
                    n_frem = r_frem - 16'd1;
                    if (n_frem == '0) n_ph = tchfe_pkg::PH_SIDLEN;
                end
                tchfe_pkg::PH_SIDLEN, tchfe_pkg::PH_COMPLEN: begin
                    if (w_nxt + W'(b) + W'(2) > w_tot) n_ph = tchfe_pkg::PH_STOP;
                    else if (b == 8'd0) n_ph = (ph0 == tchfe_pkg::PH_SIDLEN)
                        ? tchfe_pkg::PH_CSLEN0 : tchfe_pkg::PH_EXTLEN0;
                    else begin
                        n_frem = {8'd0, b}; n_ph = ph0 + 5'd1;
                    end
                end
                tchfe_pkg::PH_SKIPSID, tchfe_pkg::PH_SKIPCOMP: begin
                    n_frem = r_frem - 16'd1;
                    if (n_frem == '0) n_ph = (ph0 == tchfe_pkg::PH_SKIPSID)
                        ? tchfe_pkg::PH_CSLEN0 : tchfe_pkg::PH_EXTLEN0;
                end
                tchfe_pkg::PH_CSLEN1: begin
                    if (w_nxt + W'(v) > w_tot) n_ph = tchfe_pkg::PH_STOP;
                    else if (v == '0) n_ph = (w_nxt + W'(1) > w_tot)
                        ? tchfe_pkg::PH_STOP : tchfe_pkg::PH_COMPLEN;
                    else begin
                        n_frem = v; n_half = 1'b0; n_ph = tchfe_pkg::PH_CIPHER;
                    end
                end
                tchfe_pkg::PH_CIPHER: begin
                    if (!r_half) begin
                        n_hold = b; n_half = 1'b1;
                    end else begin
                        w_p0 = 1'b1; w_it0.item_kind = tchfe_pkg::KIND_CIPHER;
                        w_it0.item_value = v; n_half = 1'b0;
                    end
                    n_frem = r_frem - 16'd1;
                    if (n_frem == '0) n_ph = (w_nxt + W'(1) > w_tot)
                        ? tchfe_pkg::PH_STOP : tchfe_pkg::PH_COMPLEN;
                end
                tchfe_pkg::PH_EXTLEN1: begin
                    // clip the extensions area to the payload end
                    n_flim = (w_nxt + W'(v) > w_tot) ? tot0 : LB'(w_nxt + W'(v));
                    n_ph = (w_nxt + W'(4) > W'(n_flim))
                        ? tchfe_pkg::PH_STOP : tchfe_pkg::PH_ETYPE0;
                end
                tchfe_pkg::PH_ETYPE1: begin
                    n_cext = v; w_p0 = 1'b1;
                    w_it0.item_kind = tchfe_pkg::KIND_EXT_TYPE; w_it0.item_value = v;
                    n_ph = tchfe_pkg::PH_ELEN0;
                end
                tchfe_pkg::PH_ELEN1: begin
                    if (w_nxt + W'(v) > w_lim) n_ph = tchfe_pkg::PH_STOP;
                    else if (v == '0) n_ph = (w_nxt + W'(4) > w_lim)
                        ? tchfe_pkg::PH_STOP : tchfe_pkg::PH_ETYPE0;
                    else begin
                        n_bidx = '0; n_erem = v; n_list = '0;
                        if (cext0 == tchfe_pkg::EXT_SNI && v > 16'd5)
                            n_ph = tchfe_pkg::PH_SNI;
                        else if (cext0 == tchfe_pkg::EXT_SUP_VER && v > 16'd1)
                            n_ph = tchfe_pkg::PH_SV;
                        else if (cext0 == tchfe_pkg::EXT_CURVES && v > 16'd1)
                            n_ph = tchfe_pkg::PH_EC;
                        else if (cext0 == tchfe_pkg::EXT_PT_FMT && v > 16'd1)
                            n_ph = tchfe_pkg::PH_PF;
                        else n_ph = tchfe_pkg::PH_ESKIP;
                    end
                end
                tchfe_pkg::PH_SNI, tchfe_pkg::PH_SV, tchfe_pkg::PH_EC,
                tchfe_pkg::PH_PF, tchfe_pkg::PH_ESKIP: begin
                    w_k = r_bidx;
                    w_len = r_bidx + r_erem;
                    if (ph0 == tchfe_pkg::PH_SNI) begin
                        if (w_k == 16'd2) n_hold = b;
                        else if (w_k == 16'd3) n_list = {b, 8'd0};
                        else if (w_k == 16'd4) begin
                            n_list = r_list | {8'd0, b};
                            if (r_hold != 8'd0 ||
                                17'd5 + {1'b0, n_list} > {1'b0, w_len}) n_list = '0;
                        end else if (w_k >= 16'd5 && (w_k - 16'd5) < r_list) begin
                            w_p0 = 1'b1; w_it0.item_kind = tchfe_pkg::KIND_SNI_BYTE;
                            w_it0.item_value = {8'd0, b};
                        end
                    end else if (ph0 == tchfe_pkg::PH_SV) begin
                        if (w_k == '0) n_list = {8'd0, b};
                        else if (w_k[0]) n_hold = b;
                        else if ((w_k - 16'd1) < r_list) begin
                            w_p0 = 1'b1; w_it0.item_kind = tchfe_pkg::KIND_SUP_VER;
                            w_it0.item_value = v;
                        end
                    end else if (ph0 == tchfe_pkg::PH_EC) begin
                        if (w_k == '0) n_list = {b, 8'd0};
                        else if (w_k == 16'd1) n_list = r_list | {8'd0, b};
                        else if (!w_k[0]) n_hold = b;
                        else if ((w_k - 16'd2) < r_list) begin
                            w_p0 = 1'b1; w_it0.item_kind = tchfe_pkg::KIND_CURVE;
                            w_it0.item_value = v;
                        end
                    end else if (ph0 == tchfe_pkg::PH_PF) begin
                        if (w_k == '0) n_list = {8'd0, b};
                        else if ((w_k - 16'd1) < r_list) begin
                            w_p0 = 1'b1; w_it0.item_kind = tchfe_pkg::KIND_POINT_FMT;
                            w_it0.item_value = {8'd0, b};
                        end
                    end
                    n_bidx = w_k + 16'd1;
                    n_erem = r_erem - 16'd1;
                    if (n_erem == '0) n_ph = (w_nxt + W'(4) > w_lim)
                        ? tchfe_pkg::PH_STOP : tchfe_pkg::PH_ETYPE0;
                end
                default: n_ph = tchfe_pkg::PH_STOP;
            endcase
            // close the payload with its status item
            if (w_nxt >= w_tot) begin
                w_p1 = 1'b1;
                w_it1.end_of_message = 1'b1;
                w_it1.end_status = (w_tot < W'(tchfe_pkg::MIN_LEN))
                    ? tchfe_pkg::ST_TOO_SHORT : n_rej;
                n_ph = tchfe_pkg::PH_IDLE;
            end else begin
                n_pos = w_nxt[LB-1:0];
            end
        end
        if (!w_acc) begin
            n_pos = r_pos; n_total = r_total; n_flim = r_flim; n_frem = r_frem;
            n_erem = r_erem; n_cext = r_cext; n_list = r_list; n_bidx = r_bidx;
            n_hold = r_hold; n_ph = r_ph; n_rej = r_rej; n_half = r_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_total <= '0; r_flim <= '0; r_frem <= '0; r_erem <= '0;
            r_cext <= '0; r_list <= '0; r_bidx <= '0; r_hold <= '0;
            r_ph <= tchfe_pkg::PH_HDR; r_rej <= '0; r_half <= 1'b0;
        end else begin
            r_pos <= n_pos; r_total <= n_total; r_flim <= n_flim; r_frem <= n_frem;
            r_erem <= n_erem; r_cext <= n_cext; r_list <= n_list; r_bidx <= n_bidx;
            r_hold <= n_hold; r_ph <= n_ph; r_rej <= n_rej; r_half <= n_half;
        end
    end

    tchfe_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_p0),
        .i_item0 (w_it0),
        .i_push1 (w_p1),
        .i_item1 (w_it1),
        .o_room  (w_room),
        .o_res   (o_res)
    );

    // a status item always leaves the parse idle
    a_eom_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_p1 |=> r_ph == tchfe_pkg::PH_IDLE)
        else $error("status item without idle phase");
    // no pushes without an accepted byte
    a_push_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_p0 || w_p1) |-> w_acc)
        else $error("result without request");
    // value items never carry an end mark
    a_val_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_p0 |-> !w_it0.end_of_message)
        else $error("value item marked as end");
endmodule
